[design/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // result places
    localparam logic [1:0] PLACE_DATA = 2'd0;
    localparam logic [1:0] PLACE_HDR0 = 2'd1;
    localparam logic [1:0] PLACE_HDR1 = 2'd2;

    // field widths
    localparam int KIND_W  = 2;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int PLACE_W = 2;
    localparam int BC_W    = 4;
    localparam int TREE_W  = 13;

    // bit window: one held byte plus a longest code
    localparam int ACC_W   = BYTE_W + CODE_W;
    localparam int TOT_W   = 7;
    localparam int PAD_SHIFT = 5;
    localparam int PAD_W   = BYTE_W - PAD_SHIFT;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TREE_LEN = 1'b0;

    // parameter defaults
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    // result groups: up to four bytes caused by one item
    localparam int GROUP_BYTES = 4;
    localparam int GCNT_W      = 3;
    localparam int GROUP_DEPTH = 4;

    typedef struct packed {
        logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [GCNT_W-1:0]                  cnt;
        logic                               hdr;
    } t_group;

endpackage

`default_nettype wire

[design/hcbp_in_if.sv]
// ----------------------------------------------------------------------------
// hcbp_in_if
// Input channel: load, encode and finish words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [hcbp_pkg::KIND_W-1:0]   kind;
    logic [hcbp_pkg::SYM_W-1:0]    symbol;
    logic [hcbp_pkg::CODE_W-1:0]   code;
    logic [hcbp_pkg::LEN_W-1:0]    code_length;

    modport source (output valid, kind, symbol, code, code_length, input ready);
    modport sink   (input valid, kind, symbol, code, code_length, output ready);
endinterface

`default_nettype wire

[design/hcbp_out_if.sv]
// ----------------------------------------------------------------------------
// hcbp_out_if
// Output channel: emitted bytes with their file place.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_out_if;
    logic                           valid;
    logic                           ready;
    logic [hcbp_pkg::BYTE_W-1:0]    out_byte;
    logic [hcbp_pkg::PLACE_W-1:0]   out_place;
    logic                           last;

    modport source (output valid, out_byte, out_place, last, input ready);
    modport sink   (input valid, out_byte, out_place, last, output ready);
endinterface

`default_nettype wire

[design/hcbp_ram.sv]
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/hcbp_packer.sv]
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit packer: merges one looked-up code into the held byte and builds the
// group of bytes that the item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_finish,
    input  logic                           i_sym_ok,
    input  logic [hcbp_pkg::CODE_W-1:0]    i_code,
    input  logic [hcbp_pkg::LEN_W-1:0]     i_len,
    input  logic [hcbp_pkg::TREE_W-1:0]    i_tree_len,
    output logic                           o_grp_valid,
    output hcbp_pkg::t_group               o_grp
);

    logic [hcbp_pkg::BYTE_W-1:0] r_pack_byte, n_pack_byte;
    logic [hcbp_pkg::BC_W-1:0]   r_bit_count, n_bit_count;

    logic [hcbp_pkg::LEN_W-1:0]  w_len;
    logic [hcbp_pkg::TOT_W-1:0]  w_total;
    logic [hcbp_pkg::TOT_W-1:0]  w_total_m1;
    logic [hcbp_pkg::TOT_W-1:0]  w_shift;
    logic [hcbp_pkg::TOT_W-1:0]  w_rem;
    logic [hcbp_pkg::GCNT_W-1:0] w_n;
    logic [hcbp_pkg::ACC_W-1:0]  w_acc;
    logic [hcbp_pkg::ACC_W-1:0]  w_acc_sh;
    logic [hcbp_pkg::BC_W-1:0]   w_pad;

    assign w_len      = i_sym_ok ? i_len : '0;
    assign w_total    = hcbp_pkg::TOT_W'(r_bit_count) + hcbp_pkg::TOT_W'(w_len);
    assign w_total_m1 = w_total - hcbp_pkg::TOT_W'(1);
    // bytes flushed before the last new bit goes in
    assign w_n        = w_total_m1[hcbp_pkg::GCNT_W+2:3];
    assign w_shift    = hcbp_pkg::TOT_W'(hcbp_pkg::ACC_W) - hcbp_pkg::TOT_W'(r_bit_count)
                        - hcbp_pkg::TOT_W'(w_len);
    assign w_rem      = w_total - hcbp_pkg::TOT_W'({w_n, 3'b000});
    assign w_acc      = {r_pack_byte, {hcbp_pkg::CODE_W{1'b0}}}
                        | (hcbp_pkg::ACC_W'(i_code) << w_shift);
    assign w_acc_sh   = w_acc << {w_n, 3'b000};
    assign w_pad      = hcbp_pkg::BC_W'(hcbp_pkg::BYTE_W) - r_bit_count;

    always_comb begin
        n_pack_byte = r_pack_byte;
        n_bit_count = r_bit_count;
        o_grp_valid = 1'b0;
        o_grp       = '0;
        if (i_valid && i_finish) begin
            o_grp_valid    = 1'b1;
            o_grp.hdr      = 1'b1;
            o_grp.cnt      = hcbp_pkg::GCNT_W'(3);
            o_grp.bytes[0] = r_pack_byte;
            // padding of eight wraps to zero in the top three bits
            o_grp.bytes[1] = {w_pad[hcbp_pkg::PAD_W-1:0],
                              i_tree_len[hcbp_pkg::TREE_W-1:hcbp_pkg::BYTE_W]};
            o_grp.bytes[2] = i_tree_len[hcbp_pkg::BYTE_W-1:0];
            n_pack_byte    = '0;
            n_bit_count    = '0;
        end else if (i_valid && (w_len != '0)) begin
            o_grp_valid = (w_n != '0);
            o_grp.cnt   = w_n;
            for (int i = 0; i < hcbp_pkg::GROUP_BYTES; i++) begin
                o_grp.bytes[i] = w_acc[hcbp_pkg::ACC_W-1-hcbp_pkg::BYTE_W*i -: hcbp_pkg::BYTE_W];
            end
            n_pack_byte = w_acc_sh[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
            n_bit_count = w_rem[hcbp_pkg::BC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_byte <= '0;
            r_bit_count <= '0;
        end else begin
            r_pack_byte <= n_pack_byte;
            r_bit_count <= n_bit_count;
        end
    end

endmodule

`default_nettype wire

[design/hcbp_out_queue.sv]
// ----------------------------------------------------------------------------
// hcbp_out_queue
// Queue of result groups, sent out one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_out_queue (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_grp_valid,
    input  hcbp_pkg::t_group                                i_grp,
    output logic [$clog2(hcbp_pkg::GROUP_DEPTH+1)-1:0]      o_free,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]                     o_byte,
    output logic [hcbp_pkg::PLACE_W-1:0]                    o_place,
    output logic                                            o_last
);

    localparam int PW = $clog2(hcbp_pkg::GROUP_DEPTH);
    localparam int CW = $clog2(hcbp_pkg::GROUP_DEPTH + 1);
    localparam int IW = $clog2(hcbp_pkg::GROUP_BYTES);

    hcbp_pkg::t_group r_grp [hcbp_pkg::GROUP_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;

    hcbp_pkg::t_group w_head;
    logic w_take, w_pop;

    assign w_head  = r_grp[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_byte  = w_head.bytes[r_idx];
    assign o_last  = (hcbp_pkg::GCNT_W'(r_idx) + hcbp_pkg::GCNT_W'(1)) == w_head.cnt;
    assign o_free  = CW'(hcbp_pkg::GROUP_DEPTH) - r_count;
    assign w_take  = o_valid & i_ready;
    assign w_pop   = w_take & o_last;

    always_comb begin
        o_place = hcbp_pkg::PLACE_DATA;
        if (w_head.hdr) begin
            unique case (r_idx)
                IW'(0):  o_place = hcbp_pkg::PLACE_DATA;
                IW'(1):  o_place = hcbp_pkg::PLACE_HDR0;
                IW'(2):  o_place = hcbp_pkg::PLACE_HDR1;
                default: o_place = hcbp_pkg::PLACE_DATA;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_valid) begin
            r_grp[r_wr_ptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_idx    <= '0;
        end else begin
            if (i_grp_valid) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_grp_valid && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_grp_valid && w_pop) begin
                r_count <= r_count - CW'(1);
            end
            if (w_take) begin
                r_idx <= o_last ? '0 : r_idx + IW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/huffman_code_bit_packer_unit.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Table-driven Huffman encoder that packs code bits MSB-first into bytes.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries one word per item: load writes a symbol's code and length
//   into the code RAM, encode looks the symbol up and packs its bits, finish
//   sends the held byte and the two header bytes, then clears the packer.
//   o_out carries one byte per word with its place and a last flag on the
//   final byte of each item. the tree length is written over the APB port.
// Flow
//   one item is taken per cycle while i_in.ready is high; the code RAM read
//   is registered, then the packer writes the item's bytes into the queue.
//   o_out sends one byte per cycle while o_out.ready is high, so a run of
//   codes that yields more than one byte per item is paced by the output port.
// Stall and reset
//   bytes wait in a four-group queue; i_in.ready drops once the queue has
//   no room for the item in flight and a new one. reset clears the packer,
//   the queue and the tree length; code RAM entries hold nothing until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hcbp_in_if.sink                        i_in,
    hcbp_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcbp_pkg::PADDR_W-1:0]   paddr,
    input  logic [hcbp_pkg::PDATA_W-1:0]   pwdata,
    output logic [hcbp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int AW      = $clog2(SYMBOL_COUNT);
    localparam int LEN_CAP = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;
    localparam int ENT_W   = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;
    localparam int MASK_W  = hcbp_pkg::CODE_W + 1;
    localparam int FW      = $clog2(hcbp_pkg::GROUP_DEPTH + 1);

    // configuration
    logic [hcbp_pkg::TREE_W-1:0] r_tree_len;
    logic w_cfg_wr, w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[hcbp_pkg::PADDR_W-1:2] == hcbp_pkg::REG_TREE_LEN);
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign prdata    = w_reg_sel ? hcbp_pkg::PDATA_W'(r_tree_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_len <= '0;
        end else if (w_cfg_wr && w_reg_sel) begin
            r_tree_len <= pwdata[hcbp_pkg::TREE_W-1:0];
        end
    end

    // input stage and code RAM
    logic [FW-1:0]              w_free;
    logic                       w_acc, w_sym_ok, w_load;
    logic [hcbp_pkg::LEN_W-1:0] w_len_sat;
    logic [MASK_W-1:0]          w_mask;
    logic [ENT_W-1:0]           w_wdata, w_rdata;
    logic                       r_s1_valid, r_s1_finish, r_s1_sym_ok;

    assign w_acc     = i_in.valid & i_in.ready;
    assign w_sym_ok  = ({1'b0, i_in.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));
    assign w_load    = w_acc & (i_in.kind == hcbp_pkg::KIND_LOAD) & w_sym_ok;
    assign w_len_sat = (i_in.code_length > hcbp_pkg::LEN_W'(LEN_CAP))
                       ? hcbp_pkg::LEN_W'(LEN_CAP) : i_in.code_length;
    // stored codes keep only their valid bits
    assign w_mask    = (MASK_W'(1) << w_len_sat) - MASK_W'(1);
    assign w_wdata   = {i_in.code & w_mask[hcbp_pkg::CODE_W-1:0], w_len_sat};

    assign i_in.ready = (w_free > FW'(r_s1_valid));

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_in.symbol[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (i_in.symbol[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc & ((i_in.kind == hcbp_pkg::KIND_ENCODE)
                                   | (i_in.kind == hcbp_pkg::KIND_FINISH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_finish <= (i_in.kind == hcbp_pkg::KIND_FINISH);
            r_s1_sym_ok <= w_sym_ok;
        end
    end

    // packing
    logic             w_grp_valid;
    hcbp_pkg::t_group w_grp;

    hcbp_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_finish    (r_s1_finish),
        .i_sym_ok    (r_s1_sym_ok),
        .i_code      (w_rdata[ENT_W-1:hcbp_pkg::LEN_W]),
        .i_len       (w_rdata[hcbp_pkg::LEN_W-1:0]),
        .i_tree_len  (r_tree_len),
        .o_grp_valid (w_grp_valid),
        .o_grp       (w_grp)
    );

    hcbp_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (w_grp_valid),
        .i_grp       (w_grp),
        .o_free      (w_free),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_byte      (o_out.out_byte),
        .o_place     (o_out.out_place),
        .o_last      (o_out.last)
    );

endmodule

`default_nettype wire

[design/hcbp_checker.sv]
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks of the packer's output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [hcbp_pkg::BYTE_W-1:0]      i_out_byte,
    input logic [hcbp_pkg::PLACE_W-1:0]     i_out_place,
    input logic                             i_out_last
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_place)
             && $stable(i_out_last)))
        else $error("stalled output word changed");

    // nothing leaves straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // first header byte is followed at once by the second
    a_hdr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_place == hcbp_pkg::PLACE_HDR0) |=>
            (i_out_valid && i_out_place == hcbp_pkg::PLACE_HDR1))
        else $error("second header byte missing");

    // second header byte closes the finish item
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_place == hcbp_pkg::PLACE_HDR1) |-> i_out_last)
        else $error("second header byte without last");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_place (o_out.out_place),
    .i_out_last  (o_out.last)
);

`default_nettype wire
